// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL; all sample on clk and idle during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Temporal property, checked at every rising edge out of reset.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition that must hold at every rising edge out of reset.
`define ASSERT_HOLDS(lbl, expr, msg) \
    `ASSERT_PROP(lbl, (expr), msg)

`endif

// ===== sv/iibs_pkg.sv =====
package iibs_pkg;

    localparam int DEF_MAX_ROWS     = 256;
    localparam int DEF_MAX_COLS     = 256;
    localparam int FRAME_SIZE_RESET = 256;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 8;
    localparam int SIZE_W  = 9;
    localparam int SUM_W   = 24;
    localparam int RUN_W   = 16;

    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    // One classified input word as it sits in the queue.
    typedef struct packed {
        logic               is_query;
        logic               shape_err;  // zero size or outside the frame
        logic               has_top;    // row_start > 0
        logic               has_left;   // col_start > 0
        logic [PIX_W-1:0]   pixel;
        logic [SIZE_W-1:0]  row_hi;     // bottom row
        logic [COORD_W-1:0] row_lo;     // row above the box
        logic [SIZE_W-1:0]  col_hi;     // right column
        logic [COORD_W-1:0] col_lo;     // column left of the box
    } item_t;

    typedef struct packed {
        logic frame_ready;
        logic pix_write;
    } back_status_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input int unsigned maxv);
        logic [SIZE_W-1:0] res;
        if (v == '0)
            res = SIZE_W'(1);
        else if (32'(v) > maxv)
            res = SIZE_W'(maxv);
        else
            res = v;
        return res;
    endfunction

endpackage

// ===== sv/integral_image_box_sum_core.sv =====
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | s_tuser = opcode, s_tdata = pixel..col_count
// m_      | out | m_tvalid/m_tready  | m_tuser = range_error, m_tdata = box_sum
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index = register, cfg_data = value
//
// Steps: a pixel word reads the entry above in ST_IDLE, then writes in ST_PIX; a query
// reads both RAM ports in ST_IDLE and ST_QRD, adds in ST_QSUM; out of range: ST_IDLE.
// A two-word queue decouples input from the back end, so words are taken while
// the back end works or the result register waits on m_tready.
// Reset clears control only; the table RAM is not cleared, and no query reaches an
// entry before a full frame is written. Config writes always taken, restart loading.
`include "assert_macros.svh"

module integral_image_box_sum_core #(
    parameter int MAX_ROWS = iibs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = iibs_pkg::DEF_MAX_COLS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] pixel, [15:8] row_start, [23:16] col_start,
    // [32:24] row_count, [41:33] col_count, [47:42] zero
    input  logic [47:0]                    s_tdata,
    // [0] opcode
    input  logic                           s_tuser,
    // result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [23:0] box_sum
    output logic [23:0]                    m_tdata,
    // [0] range_error
    output logic                           m_tuser,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [iibs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iibs_pkg::SIZE_W-1:0]    cfg_data
);
    import iibs_pkg::*;

    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int TABLE_DEPTH = MAX_ROWS * (2 ** COL_W);
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam logic [SIZE_W-1:0] WIDTH_RESET  =
        clamp_size(SIZE_W'(FRAME_SIZE_RESET), MAX_COLS);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET =
        clamp_size(SIZE_W'(FRAME_SIZE_RESET), MAX_ROWS);

    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;

    item_t             front_item;
    item_t             head_item;
    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SUM_W-1:0]  ram_wdata;
    logic              ram_re_a;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [SUM_W-1:0]  ram_rdata_a;
    logic              ram_re_b;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [SUM_W-1:0]  ram_rdata_b;

    back_status_t      st;
    logic              cfg_write;

    // ---- configuration registers (out-of-range sizes clamped on write) ----
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= clamp_size(cfg_data, MAX_COLS);
                REG_FRAME_HEIGHT: frame_height_reg <= clamp_size(cfg_data, MAX_ROWS);
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // ---- front: decode and range check, then queue ----
    iibs_front u_front (
        .tdata        (s_tdata),
        .tuser        (s_tuser),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .item         (front_item)
    );

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    iibs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    // ---- back: table build and box sums ----
    iibs_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (cfg_write),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .item_valid   (!q_empty),
        .item         (head_item),
        .pop          (q_pop),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re_a     (ram_re_a),
        .ram_raddr_a  (ram_raddr_a),
        .ram_rdata_a  (ram_rdata_a),
        .ram_re_b     (ram_re_b),
        .ram_raddr_b  (ram_raddr_b),
        .ram_rdata_b  (ram_rdata_b),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_sum      (m_tdata),
        .out_err      (m_tuser),
        .status       (st)
    );

    // summed-area table, one entry per pixel position
    iibs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .re_b    (ram_re_b),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    // ---- checks ----
    `ASSERT_HOLDS(a_err_zero, !(m_tvalid && m_tuser) || (m_tdata == '0), "error word with a sum")
    `ASSERT_PROP(a_cfg_clear, cfg_write |=> !st.frame_ready, "frame_ready kept after cfg")
    `ASSERT_PROP(a_ready_pix, $rose(st.frame_ready) |-> $past(st.pix_write), "ready without pixel")

endmodule

// ===== sv/iibs_ram.sv =====
module iibs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re_a,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [WIDTH-1:0]  rdata_a,
    input  logic              re_b,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re_a)
            rdata_a_reg <= mem_reg[raddr_a];
        if (re_b)
            rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== sv/iibs_front.sv =====
module iibs_front (
    input  logic [47:0]                tdata,
    input  logic                       tuser,
    input  logic [iibs_pkg::SIZE_W-1:0] frame_width,
    input  logic [iibs_pkg::SIZE_W-1:0] frame_height,
    output iibs_pkg::item_t            item
);
    import iibs_pkg::*;

    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] row_start;
    logic [COORD_W-1:0] col_start;
    logic [SIZE_W-1:0]  row_count;
    logic [SIZE_W-1:0]  col_count;
    logic [SIZE_W:0]    row_end;
    logic [SIZE_W:0]    col_end;

    assign pixel     = tdata[7:0];
    assign row_start = tdata[15:8];
    assign col_start = tdata[23:16];
    assign row_count = tdata[32:24];
    assign col_count = tdata[41:33];

    // one past the last row / column of the box
    assign row_end = {2'b00, row_start} + {1'b0, row_count};
    assign col_end = {2'b00, col_start} + {1'b0, col_count};

    always_comb
    begin
        item.is_query  = (opcode_t'(tuser) == OP_QUERY);
        item.shape_err = (row_count == '0) || (col_count == '0)
                       || (row_end > {1'b0, frame_height})
                       || (col_end > {1'b0, frame_width});
        item.has_top   = (row_start != '0);
        item.has_left  = (col_start != '0);
        item.pixel     = pixel;
        item.row_hi    = SIZE_W'(row_end - 10'd1);
        item.col_hi    = SIZE_W'(col_end - 10'd1);
        item.row_lo    = row_start - 8'd1;
        item.col_lo    = col_start - 8'd1;
    end

endmodule

// ===== sv/iibs_fifo.sv =====
module iibs_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iibs_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output iibs_pkg::item_t head_item,
    output logic            empty
);
    import iibs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== sv/iibs_back.sv =====
module iibs_back #(
    parameter int MAX_ROWS = iibs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = iibs_pkg::DEF_MAX_COLS,
    localparam int ROW_W  = $clog2(MAX_ROWS),
    localparam int COL_W  = $clog2(MAX_COLS),
    localparam int ADDR_W = ROW_W + COL_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        restart,
    input  logic [iibs_pkg::SIZE_W-1:0] frame_width,
    input  logic [iibs_pkg::SIZE_W-1:0] frame_height,
    input  logic                        item_valid,
    input  iibs_pkg::item_t             item,
    output logic                        pop,
    output logic                        ram_we,
    output logic [ADDR_W-1:0]           ram_waddr,
    output logic [iibs_pkg::SUM_W-1:0]  ram_wdata,
    output logic                        ram_re_a,
    output logic [ADDR_W-1:0]           ram_raddr_a,
    input  logic [iibs_pkg::SUM_W-1:0]  ram_rdata_a,
    output logic                        ram_re_b,
    output logic [ADDR_W-1:0]           ram_raddr_b,
    input  logic [iibs_pkg::SUM_W-1:0]  ram_rdata_b,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [iibs_pkg::SUM_W-1:0]  out_sum,
    output logic                        out_err,
    output iibs_pkg::back_status_t      status
);
    import iibs_pkg::*;

    localparam int RCMP_W = ((ROW_W > SIZE_W) ? ROW_W : SIZE_W) + 1;
    localparam int CCMP_W = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PIX  = 4'b0010,
        ST_QRD  = 4'b0100,
        ST_QSUM = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   load_row_reg, load_row_next;
    logic [COL_W-1:0]   load_col_reg, load_col_next;
    logic [RUN_W-1:0]   run_sum_reg, run_sum_next;
    logic               frame_ready_reg, frame_ready_next;
    item_t              cur_reg;
    logic [SUM_W-1:0]   part_reg, part_next;
    logic               out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]   out_sum_reg, out_sum_next;
    logic               out_err_reg, out_err_next;

    logic               slot_free;
    logic               load;
    logic [RUN_W-1:0]   run_add;
    logic               col_wrap;
    logic               row_wrap;

    assign slot_free = !out_valid_reg || out_ready;
    assign run_add   = run_sum_reg + RUN_W'(cur_reg.pixel);
    assign col_wrap  = (CCMP_W'(load_col_reg) + CCMP_W'(1)) >= CCMP_W'(frame_width);
    assign row_wrap  = (RCMP_W'(load_row_reg) + RCMP_W'(1)) >= RCMP_W'(frame_height);

    always_comb
    begin
        state_next       = state_reg;
        load_row_next    = load_row_reg;
        load_col_next    = load_col_reg;
        run_sum_next     = run_sum_reg;
        frame_ready_next = frame_ready_reg;
        part_next        = part_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_sum_next     = out_sum_reg;
        out_err_next     = out_err_reg;
        pop              = 1'b0;
        load             = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = {load_row_reg, load_col_reg};
        ram_wdata        = SUM_W'(run_add);
        ram_re_a         = 1'b0;
        ram_raddr_a      = {ROW_W'(item.row_hi), COL_W'(item.col_hi)};
        ram_re_b         = 1'b0;
        ram_raddr_b      = {ROW_W'(item.row_lo), COL_W'(item.col_hi)};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (!item.is_query)
                    begin
                        // fetch the entry above the pixel
                        pop         = 1'b1;
                        load        = 1'b1;
                        ram_re_a    = (load_row_reg != '0);
                        ram_raddr_a = {load_row_reg - 1'b1, load_col_reg};
                        state_next  = ST_PIX;
                    end
                    else if (item.shape_err || !frame_ready_reg)
                    begin
                        if (slot_free)
                        begin
                            pop            = 1'b1;
                            out_valid_next = 1'b1;
                            out_sum_next   = '0;
                            out_err_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        // bottom-right and top-right corners
                        pop        = 1'b1;
                        load       = 1'b1;
                        ram_re_a   = 1'b1;
                        ram_re_b   = item.has_top;
                        state_next = ST_QRD;
                    end
                end
            end
            ST_PIX:
            begin
                ram_we    = 1'b1;
                ram_wdata = SUM_W'(run_add)
                          + ((load_row_reg != '0) ? ram_rdata_a : '0);
                if (col_wrap)
                begin
                    load_col_next = '0;
                    run_sum_next  = '0;
                    if (row_wrap)
                    begin
                        load_row_next    = '0;
                        frame_ready_next = 1'b1;
                    end
                    else
                        load_row_next = load_row_reg + 1'b1;
                end
                else
                begin
                    load_col_next = load_col_reg + 1'b1;
                    run_sum_next  = run_add;
                end
                state_next = ST_IDLE;
            end
            ST_QRD:
            begin
                // bottom-left and top-left corners
                ram_re_a    = cur_reg.has_left;
                ram_raddr_a = {ROW_W'(cur_reg.row_hi), COL_W'(cur_reg.col_lo)};
                ram_re_b    = cur_reg.has_left && cur_reg.has_top;
                ram_raddr_b = {ROW_W'(cur_reg.row_lo), COL_W'(cur_reg.col_lo)};
                part_next   = ram_rdata_a - (cur_reg.has_top ? ram_rdata_b : '0);
                state_next  = ST_QSUM;
            end
            ST_QSUM:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_err_next   = 1'b0;
                    out_sum_next   = part_reg
                                   - (cur_reg.has_left ? ram_rdata_a : '0)
                                   + ((cur_reg.has_left && cur_reg.has_top) ?
                                      ram_rdata_b : '0);
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (restart)
        begin
            load_row_next    = '0;
            load_col_next    = '0;
            run_sum_next     = '0;
            frame_ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            load_row_reg    <= '0;
            load_col_reg    <= '0;
            run_sum_reg     <= '0;
            frame_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            load_row_reg    <= load_row_next;
            load_col_reg    <= load_col_next;
            run_sum_reg     <= run_sum_next;
            frame_ready_reg <= frame_ready_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= item;
        part_reg    <= part_next;
        out_sum_reg <= out_sum_next;
        out_err_reg <= out_err_next;
    end

    assign out_valid          = out_valid_reg;
    assign out_sum            = out_sum_reg;
    assign out_err            = out_err_reg;
    assign status.frame_ready = frame_ready_reg;
    assign status.pix_write   = (state_reg == ST_PIX);

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import iibs_pkg::*;

    // One input word as the stimulus sees it.
    typedef struct {
        opcode_t          op;
        bit [PIX_W-1:0]   pixel;
        bit [COORD_W-1:0] row_start;
        bit [COORD_W-1:0] col_start;
        bit [SIZE_W-1:0]  row_count;
        bit [SIZE_W-1:0]  col_count;
    } box_word_t;

    // One rectangle result.
    typedef struct {
        bit [SUM_W-1:0] box_sum;
        bit             range_err;
    } box_result_t;

    // Summed-area table predictor plus the queue of pending rectangle results.
    class box_sum_scoreboard;
        bit [SUM_W-1:0] sat_table [DEF_MAX_ROWS*DEF_MAX_COLS];
        int unsigned    load_row;
        int unsigned    load_col;
        bit [RUN_W-1:0] row_sum;
        bit             frame_ready;
        int unsigned    frame_w;
        int unsigned    frame_h;
        box_result_t    sum_q [$];
        int unsigned    fail_count;
        int unsigned    pixel_count;
        int unsigned    query_count;
        int unsigned    range_err_count;

        function new();
            frame_w = DEF_MAX_COLS;
            frame_h = DEF_MAX_ROWS;
            restart_frame();
        endfunction

        function void restart_frame();
            load_row    = 0;
            load_col    = 0;
            row_sum     = '0;
            frame_ready = 1'b0;
        endfunction

        function int unsigned clamp_dim(bit [SIZE_W-1:0] v, int unsigned maxv);
            if (v == 0)
                return 1;
            if (32'(v) > maxv)
                return maxv;
            return 32'(v);
        endfunction

        function int unsigned slot(int unsigned r, int unsigned c);
            return r * DEF_MAX_COLS + c;
        endfunction

        function int unsigned pending();
            return sum_q.size();
        endfunction

        function void write_reg(cfg_reg_t idx, bit [SIZE_W-1:0] v);
            if (idx == REG_FRAME_WIDTH)
                frame_w = clamp_dim(v, DEF_MAX_COLS);
            else
                frame_h = clamp_dim(v, DEF_MAX_ROWS);
            restart_frame();
        endfunction

        function void note_word(box_word_t w);
            bit [SUM_W-1:0] entry;
            int unsigned    r0, c0, rn, cn, r1, c1;
            box_result_t    res;
            if (w.op == OP_PIXEL)
            begin
                pixel_count++;
                row_sum = row_sum + RUN_W'(w.pixel);
                entry   = SUM_W'(row_sum);
                if (load_row > 0)
                    entry = entry + sat_table[slot(load_row - 1, load_col)];
                sat_table[slot(load_row, load_col)] = entry;
                if (load_col + 1 >= frame_w)
                begin
                    load_col = 0;
                    row_sum  = '0;
                    if (load_row + 1 >= frame_h)
                    begin
                        load_row    = 0;
                        frame_ready = 1'b1;
                    end
                    else
                        load_row++;
                end
                else
                    load_col++;
            end
            else
            begin
                query_count++;
                r0 = 32'(w.row_start);
                c0 = 32'(w.col_start);
                rn = 32'(w.row_count);
                cn = 32'(w.col_count);
                res.box_sum   = '0;
                res.range_err = 1'b1;
                if (frame_ready && rn != 0 && cn != 0
                    && r0 + rn <= frame_h && c0 + cn <= frame_w)
                begin
                    r1 = r0 + rn - 1;
                    c1 = c0 + cn - 1;
                    res.range_err = 1'b0;
                    res.box_sum   = sat_table[slot(r1, c1)];
                    if (r0 > 0)
                        res.box_sum = res.box_sum - sat_table[slot(r0 - 1, c1)];
                    if (c0 > 0)
                        res.box_sum = res.box_sum - sat_table[slot(r1, c0 - 1)];
                    if (r0 > 0 && c0 > 0)
                        res.box_sum = res.box_sum + sat_table[slot(r0 - 1, c0 - 1)];
                end
                sum_q.insert(sum_q.size(), res);
            end
        endfunction

        function void check_result(bit [SUM_W-1:0] box_sum, bit range_err);
            box_result_t want;
            if (sum_q.size() == 0)
            begin
                $display("%0t: unexpected result word: box_sum %0d range_error %0b",
                         $time, box_sum, range_err);
                fail_count++;
                return;
            end
            want = sum_q.pop_front();
            if (range_err)
                range_err_count++;
            if (want.box_sum != box_sum)
            begin
                $display("%0t: box_sum mismatch: expected %0d, actual %0d",
                         $time, want.box_sum, box_sum);
                fail_count++;
            end
            if (want.range_err != range_err)
            begin
                $display("%0t: range_error mismatch: expected %0b, actual %0b",
                         $time, want.range_err, range_err);
                fail_count++;
            end
        endfunction
    endclass

    localparam int CLK_HALF        = 6;     // 12 ns period
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no word moving on any channel
    localparam int SETTLE_CYCLES   = 16;    // 2-word queue + back end, with margin
    localparam int HOLD_OFF_CYCLES = 300;   // long output stall, fills the queue

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data  = '0;

    // idle odds in percent, per side; changed between phases
    int send_idle_pct = 7;
    int recv_idle_pct = 87;
    bit hold_off_req  = 1'b0;
    int idle_cycles   = 0;
    int setting_count = 0;

    box_sum_scoreboard sb;

    integral_image_box_sum_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin : clock_gen
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Word builders. Unused fields get random values: the block must
    // ignore query fields on a pixel word and the pixel on a query.
    // ---------------------------------------------------------------
    function automatic box_word_t pixel_word(bit [PIX_W-1:0] p);
        box_word_t w;
        w.op        = OP_PIXEL;
        w.pixel     = p;
        w.row_start = COORD_W'($urandom_range(255));
        w.col_start = COORD_W'($urandom_range(255));
        w.row_count = SIZE_W'($urandom_range(511));
        w.col_count = SIZE_W'($urandom_range(511));
        return w;
    endfunction

    function automatic box_word_t query_word(bit [COORD_W-1:0] r0, bit [COORD_W-1:0] c0,
                                             bit [SIZE_W-1:0] rn, bit [SIZE_W-1:0] cn);
        box_word_t w;
        w.op        = OP_QUERY;
        w.pixel     = PIX_W'($urandom_range(255));
        w.row_start = r0;
        w.col_start = c0;
        w.row_count = rn;
        w.col_count = cn;
        return w;
    endfunction

    // rectangle that fits the current frame size
    function automatic box_word_t in_range_query();
        int unsigned r0, c0;
        r0 = $urandom_range(sb.frame_h - 1, 0);
        c0 = $urandom_range(sb.frame_w - 1, 0);
        return query_word(COORD_W'(r0), COORD_W'(c0),
                          SIZE_W'($urandom_range(sb.frame_h - r0, 1)),
                          SIZE_W'($urandom_range(sb.frame_w - c0, 1)));
    endfunction

    // any field values at all, mostly out of range
    function automatic box_word_t noise_query();
        return query_word(COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                          SIZE_W'($urandom_range(511)), SIZE_W'($urandom_range(511)));
    endfunction

    // pixels (which start overwriting the frame) mixed with queries
    function automatic box_word_t mixed_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return pixel_word(PIX_W'($urandom_range(255)));
        else if (pick < 90)
            return in_range_query();
        else
            return noise_query();
    endfunction

    // ---------------------------------------------------------------
    // Input side. Called at a falling edge, returns at a falling edge.
    // tvalid is left high after a word so back-to-back words never
    // lower and raise it in the same step.
    // ---------------------------------------------------------------
    task automatic send_word(box_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {6'b0, w.col_count, w.row_count, w.col_start, w.row_start, w.pixel};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(w);
        @(negedge clk);
    endtask

    // Wait for every pending result, then let trailing pixel writes finish.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Both registers back to back; cfg_valid stays high across the pair.
    task automatic write_frame_size(bit [SIZE_W-1:0] w_raw, bit [SIZE_W-1:0] h_raw);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w_raw;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(REG_FRAME_WIDTH, w_raw);
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h_raw;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(REG_FRAME_HEIGHT, h_raw);
        @(negedge clk);
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // New frame size: a couple of early queries (no frame yet), one full
    // frame with a little noise, then a mix that overwrites the frame.
    task automatic run_setting(bit [SIZE_W-1:0] w_raw, bit [SIZE_W-1:0] h_raw,
                               int n_mixed, bit with_hold_off);
        int n_pix;
        drain();
        write_frame_size(w_raw, h_raw);
        send_word(in_range_query());
        send_word(noise_query());
        n_pix = sb.frame_w * sb.frame_h;
        repeat (n_pix)
        begin
            if ($urandom_range(99) < 4)
                send_word(noise_query());
            send_word(pixel_word(PIX_W'($urandom_range(255))));
        end
        if (with_hold_off)
            hold_off_req = 1'b1;
        repeat (n_mixed) send_word(mixed_word());
    endtask

    // ---------------------------------------------------------------
    // Output side: random tready, or a long hold-off on request.
    // ---------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // no word on any channel for too long: hang
    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int k;
        sb = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase 1: sender rarely idles, receiver mostly stalls.
        send_idle_pct = 7;
        recv_idle_pct = 87;

        // out of reset the 256x256 frame is not loaded: range error
        send_word(query_word(0, 0, 1, 1));
        drain();
        write_frame_size(3, 2);
        send_word(query_word(0, 0, 1, 1));          // still no frame
        send_word(pixel_word(8'd255));
        send_word(pixel_word(8'd0));
        send_word(pixel_word(8'd255));
        send_word(pixel_word(8'd1));
        send_word(pixel_word(8'd128));
        send_word(pixel_word(8'd255));              // frame complete
        send_word(query_word(0, 0, 2, 3));          // whole frame, no edges dropped
        send_word(query_word(0, 0, 1, 1));          // top-left corner
        send_word(query_word(1, 2, 1, 1));          // bottom-right, all four reads
        send_word(query_word(1, 1, 1, 2));          // top and left corrections
        send_word(query_word(0, 1, 2, 1));          // left correction only
        send_word(query_word(0, 0, 0, 1));          // zero height
        send_word(query_word(0, 0, 1, 0));          // zero width
        send_word(query_word(1, 0, 2, 1));          // past the bottom
        send_word(query_word(0, 1, 1, 3));          // past the right
        send_word(query_word(8'd255, 8'd255, 9'd511, 9'd511));
        send_word(pixel_word(8'd7));                // next frame starts over the old one
        send_word(query_word(0, 0, 2, 3));          // mix of new and old rows

        // widest frame, one row; out-of-range raw values get clamped
        run_setting(9'd511, 9'd0, 20, 1'b0);

        // Phase 2: the other way round.
        send_idle_pct = 87;
        recv_idle_pct = 7;
        run_setting(9'd1, 9'd256, 20, 1'b0);

        // Phase 3: no idling, small frames; first one gets the long hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < 3; k++)
            run_setting(SIZE_W'($urandom_range(6, 1)), SIZE_W'($urandom_range(6, 1)),
                        25, k == 0);

        drain();
        $display("Covered %0d pixel loads and %0d queries, %0d of them range errors,",
                 sb.pixel_count, sb.query_count, sb.range_err_count);
        $display("over %0d frame sizes incl. 256x1 and 1x256, with stalls on both sides.",
                 setting_count);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
